FILE: hdl/aavg_pkg.sv
// ----------------------------------------------------------------------------
// aavg_pkg
// Shared widths, CORDIC constants and arctangent table for the ring sector
// vertex generator.
// ----------------------------------------------------------------------------
package aavg_pkg;

    localparam int ANGLE_W  = 16;   // binary angle, one turn = 2^16
    localparam int SWEEP_W  = 17;
    localparam int COUNT_W  = 6;
    localparam int COORD_W  = 32;
    localparam int TRIG_W   = 34;   // Q2.30 with headroom, also CORDIC z
    localparam int PROD_W   = COORD_W + 1 + TRIG_W;
    localparam int ATAN_N   = 24;
    localparam int ATAN_IW  = 5;

    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;

    // arctan(2^-k), 2^32 = one turn
    function automatic logic signed [TRIG_W-1:0] atan_lut(input logic [ATAN_IW-1:0] k);
        logic signed [TRIG_W-1:0] v;
        case (k)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933405;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41721;
            5'd15:   v = 34'sd20860;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2607;
            5'd19:   v = 34'sd1303;
            5'd20:   v = 34'sd651;
            5'd21:   v = 34'sd325;
            5'd22:   v = 34'sd162;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/aavg_div.sv
// ----------------------------------------------------------------------------
// aavg_div
// Bit-serial restoring divider: sweep / segment count, one quotient bit a
// cycle.
// ----------------------------------------------------------------------------
module aavg_div
    import aavg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SWEEP_W-1:0] dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic [SWEEP_W-1:0] quotient,
    output logic [COUNT_W-1:0] remainder,
    output logic               done
);

    localparam int CNT_W = $clog2(SWEEP_W);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SWEEP_W-1:0] q_reg, q_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] div_reg, div_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;

    assign trial = {rem_reg, q_reg[SWEEP_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract where it fits
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = COUNT_W'(trial - {1'b0, div_reg});
                q_next   = {q_reg[SWEEP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COUNT_W-1:0];
                q_next   = {q_reg[SWEEP_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SWEEP_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient  = q_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

FILE: hdl/aavg_cordic.sv
// ----------------------------------------------------------------------------
// aavg_cordic
// Iterative rotation-mode CORDIC: one micro-rotation a cycle on a shared
// shift and add datapath, quadrant folded in at the output.
// ----------------------------------------------------------------------------
module aavg_cordic
    import aavg_pkg::*;
#(
    parameter int ITERATIONS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ANGLE_W-1:0]       angle,
    output logic signed [TRIG_W-1:0] cos_val,
    output logic signed [TRIG_W-1:0] sin_val,
    output logic                     done
);

    localparam int ITERS = (ITERATIONS > ATAN_N) ? ATAN_N : ITERATIONS;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [ATAN_IW-1:0]       k_reg, k_next;
    logic signed [TRIG_W-1:0] x_reg, x_next;
    logic signed [TRIG_W-1:0] y_reg, y_next;
    logic signed [TRIG_W-1:0] z_reg, z_next;
    logic [1:0]               quad_reg, quad_next;
    logic signed [TRIG_W-1:0] dx, dy, da;

    assign dx = y_reg >>> k_reg;
    assign dy = x_reg >>> k_reg;
    assign da = atan_lut(k_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        quad_next = quad_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            x_next    = GAIN_Q30;
            y_next    = '0;
            z_next    = TRIG_W'({angle[ANGLE_W-3:0], 16'h0000});
            quad_next = angle[ANGLE_W-1:ANGLE_W-2];
        end
        else if (busy_reg)
        begin
            if (!z_reg[TRIG_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end
            k_next = k_reg + 1'b1;
            if (k_reg == ATAN_IW'(ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
    end

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_val = x_reg;
                sin_val = y_reg;
            end
            2'd1:
            begin
                cos_val = -y_reg;
                sin_val = x_reg;
            end
            2'd2:
            begin
                cos_val = -x_reg;
                sin_val = -y_reg;
            end
            default:
            begin
                cos_val = y_reg;
                sin_val = -x_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule

FILE: hdl/aavg_vertex.sv
// ----------------------------------------------------------------------------
// aavg_vertex
// One shared multiplier scales cos and sin by both radii in turn; each
// product is rounded, offset by the center and saturated.
// ----------------------------------------------------------------------------
module aavg_vertex
    import aavg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic [COORD_W-1:0]        inner_radius,
    input  logic [COORD_W-1:0]        outer_radius,
    input  logic signed [TRIG_W-1:0]  cos_val,
    input  logic signed [TRIG_W-1:0]  sin_val,
    output logic signed [COORD_W-1:0] inner_x,
    output logic signed [COORD_W-1:0] inner_y,
    output logic signed [COORD_W-1:0] outer_x,
    output logic signed [COORD_W-1:0] outer_y,
    output logic                      done
);

    localparam int SCALED_W = PROD_W + 1 - 30;
    localparam int SUM_W    = SCALED_W + 1;
    localparam logic signed [PROD_W:0]  ROUND_HALF = (PROD_W + 1)'(64'sh2000_0000);
    localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_MIN    = -SUM_W'(64'sh8000_0000);

    logic                      busy_reg, busy_next;
    logic                      add_phase_reg, add_phase_next;
    logic [1:0]                sel_reg, sel_next;
    logic                      done_reg, done_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic [COORD_W-1:0]        radius_mux;
    logic signed [TRIG_W-1:0]  trig_mux;
    logic signed [COORD_W-1:0] center_mux;
    logic signed [PROD_W:0]    rounded;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SUM_W-1:0]   sum;
    logic signed [COORD_W-1:0] coord;
    logic signed [COORD_W-1:0] ix_reg, iy_reg, ox_reg, oy_reg;

    // sel bit 1 picks the radius, bit 0 picks sin over cos
    assign radius_mux = sel_reg[1] ? outer_radius : inner_radius;
    assign trig_mux   = sel_reg[0] ? sin_val : cos_val;
    assign center_mux = sel_reg[0] ? center_y : center_x;
    assign prod_next  = $signed({1'b0, radius_mux}) * trig_mux;

    assign rounded = {prod_reg[PROD_W-1], prod_reg} + ROUND_HALF;
    assign scaled  = rounded[PROD_W:30];
    assign sum     = {scaled[SCALED_W-1], scaled} + SUM_W'(center_mux);

    always_comb
    begin
        if (sum > SAT_MAX)
            coord = SAT_MAX[COORD_W-1:0];
        else if (sum < SAT_MIN)
            coord = SAT_MIN[COORD_W-1:0];
        else
            coord = sum[COORD_W-1:0];
    end

    always_comb
    begin
        busy_next      = busy_reg;
        add_phase_next = add_phase_reg;
        sel_next       = sel_reg;
        done_next      = 1'b0;
        if (start)
        begin
            busy_next      = 1'b1;
            add_phase_next = 1'b0;
            sel_next       = '0;
        end
        else if (busy_reg)
        begin
            add_phase_next = !add_phase_reg;
            if (add_phase_reg)
            begin
                sel_next = sel_reg + 1'b1;
                if (sel_reg == 2'd3)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            add_phase_reg <= 1'b0;
            sel_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            add_phase_reg <= add_phase_next;
            sel_reg       <= sel_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !add_phase_reg)
            prod_reg <= prod_next;
        if (busy_reg && add_phase_reg)
        begin
            case (sel_reg)
                2'd0:    ix_reg <= coord;
                2'd1:    iy_reg <= coord;
                2'd2:    ox_reg <= coord;
                default: oy_reg <= coord;
            endcase
        end
    end

    assign inner_x = ix_reg;
    assign inner_y = iy_reg;
    assign outer_x = ox_reg;
    assign outer_y = oy_reg;
    assign done    = done_reg;

endmodule

FILE: hdl/annulus_arc_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// annulus_arc_vertex_generator_core
// Ring sector tessellation: one request in, N+1 inner/outer vertex pairs out.
//
//   channel  direction  payload
//   s_axis   in         centre x/y, radii, start, sweep, segment count
//   m_axis   out        point index, inner x/y, outer x/y; tlast on final pair
//
// A request first runs the sweep / N divider; each pair then passes through
// the angle load, the CORDIC (steps capped at 24), the shared multiplier
// and the output state, and the sequencer returns to idle before the next
// request is taken.
// s_tready is high only when idle; a stalled m_axis holds the whole block.
// Reset is asynchronous, active low, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module annulus_arc_vertex_generator_core
    import aavg_pkg::*;
#(
    parameter int MAX_SEGMENTS      = 63,
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // center_x[31:0], center_y[63:32], inner_radius[95:64],
    // outer_radius[127:96], start_angle[143:128], sweep_angle[160:144],
    // segment_count[166:161], zero pad[167]
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_index[5:0], inner_x[37:6], inner_y[69:38], outer_x[101:70],
    // outer_y[133:102], zero pad[135:134]
    output logic [135:0] m_tdata,
    output logic         m_tlast
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_ANG  = 6'b000100,
        ST_CORD = 6'b001000,
        ST_VTX  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_SEGMENTS);

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   n_reg, n_next;
    logic [COUNT_W-1:0]   idx_reg, idx_next;
    logic [ANGLE_W-1:0]   qacc_reg, qacc_next;
    logic [COUNT_W-1:0]   racc_reg, racc_next;
    logic [COORD_W-1:0]   cx_reg, cy_reg, rin_reg, rout_reg;
    logic [ANGLE_W-1:0]   start_reg;
    logic [SWEEP_W-1:0]   sweep_reg;
    logic [COUNT_W-1:0]   n_in, n_eff;
    logic [COUNT_W:0]     rsum;
    logic                 in_fire, out_fire;

    logic [SWEEP_W-1:0]   step_q;
    logic [COUNT_W-1:0]   step_r;
    logic                 div_done;
    logic signed [TRIG_W-1:0] cos_val, sin_val;
    logic                 cordic_done;
    logic signed [COORD_W-1:0] inner_x, inner_y, outer_x, outer_y;
    logic                 vtx_done;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    assign n_in  = s_tdata[166:161];
    assign n_eff = (n_in == '0) ? COUNT_W'(1) : ((n_in > MAX_N) ? MAX_N : n_in);
    assign rsum  = {1'b0, racc_reg} + {1'b0, step_r};

    aavg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire),
        .dividend  (s_tdata[160:144]),
        .divisor   (n_eff),
        .quotient  (step_q),
        .remainder (step_r),
        .done      (div_done)
    );

    aavg_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == ST_ANG),
        .angle   (start_reg + qacc_reg),
        .cos_val (cos_val),
        .sin_val (sin_val),
        .done    (cordic_done)
    );

    aavg_vertex u_vertex (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cordic_done),
        .center_x     (cx_reg),
        .center_y     (cy_reg),
        .inner_radius (rin_reg),
        .outer_radius (rout_reg),
        .cos_val      (cos_val),
        .sin_val      (sin_val),
        .inner_x      (inner_x),
        .inner_y      (inner_y),
        .outer_x      (outer_x),
        .outer_y      (outer_y),
        .done         (vtx_done)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        qacc_next  = qacc_reg;
        racc_next  = racc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    n_next     = n_eff;
                    idx_next   = '0;
                    qacc_next  = '0;
                    racc_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_ANG;
            end
            ST_ANG:
            begin
                state_next = ST_CORD;
            end
            ST_CORD:
            begin
                if (cordic_done)
                    state_next = ST_VTX;
            end
            ST_VTX:
            begin
                if (vtx_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    if (idx_reg == n_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        // advance floor(i*sweep/N) by quotient plus carry
                        idx_next = idx_reg + 1'b1;
                        if (rsum >= {1'b0, n_reg})
                        begin
                            racc_next = COUNT_W'(rsum - {1'b0, n_reg});
                            qacc_next = qacc_reg + step_q[ANGLE_W-1:0] + 1'b1;
                        end
                        else
                        begin
                            racc_next = rsum[COUNT_W-1:0];
                            qacc_next = qacc_reg + step_q[ANGLE_W-1:0];
                        end
                        state_next = ST_ANG;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            idx_reg   <= '0;
            qacc_reg  <= '0;
            racc_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            qacc_reg  <= qacc_next;
            racc_reg  <= racc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cx_reg    <= s_tdata[31:0];
            cy_reg    <= s_tdata[63:32];
            rin_reg   <= s_tdata[95:64];
            rout_reg  <= s_tdata[127:96];
            start_reg <= s_tdata[143:128];
            sweep_reg <= s_tdata[160:144];
        end
    end

    assign m_tdata = {2'b00, outer_y, outer_x, inner_y, inner_x, idx_reg};
    assign m_tlast = (idx_reg == n_reg);

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (idx_reg <= n_reg) && (n_reg != '0))
        else $error("point index beyond segment count");

    a_next_point: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !m_tlast) |=> (state_reg == ST_ANG) && (idx_reg == $past(idx_reg) + 1'b1))
        else $error("next vertex pair not started");

    a_request_divides: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_DIV) && (sweep_reg == $past(s_tdata[160:144])))
        else $error("request not latched");
`endif

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring sector vertex generator. Requests go in on
// the slave stream. A built-in CORDIC predictor works out every inner/outer
// vertex pair, and each pair that leaves the master stream is compared with
// the oldest expected pair. Phases cover directed corner cases, random rings
// with and without sender gaps and receiver stalls, and a long receiver
// hold-off that backs the block up onto its input.
// ----------------------------------------------------------------------------
module tb_top;
    import aavg_pkg::*;

    localparam int SEG_MAX      = 63;
    localparam int CORDIC_STEPS = 16;
    localparam int IDLE_LIMIT   = 5000;   // cycles with no transaction on either side
    localparam int HOLD_CYCLES  = 400;
    localparam longint CORDIC_K = 64'sd652032874;

    localparam longint ARCTAN [0:23] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41721, 20860, 10430, 5215,
        2607, 1303, 651, 325, 162, 81
    };

    typedef struct {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [COORD_W-1:0]        r_in;
        logic [COORD_W-1:0]        r_out;
        logic [ANGLE_W-1:0]        start;
        logic [SWEEP_W-1:0]        sweep;
        logic [COUNT_W-1:0]        segs;
    } ring_t;

    typedef struct {
        logic [COUNT_W-1:0] idx;
        logic [COORD_W-1:0] ix;
        logic [COORD_W-1:0] iy;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic               last;
    } vertex_pair_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tlast;

    vertex_pair_t pending_pairs[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_left = 0;
    int           errors = 0;
    int           rings_sent = 0;
    int           pairs_checked = 0;

    annulus_arc_vertex_generator_core #(
        .MAX_SEGMENTS      (SEG_MAX),
        .CORDIC_ITERATIONS (CORDIC_STEPS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic cordic_cos_sin(input logic [ANGLE_W-1:0] ang,
                                  output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = CORDIC_K;
        y = 0;
        z = longint'({ang[13:0], 16'h0000});
        for (int k = 0; k < CORDIC_STEPS && k < 24; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[k];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[k];
            end
        end
        // fold the first-quadrant result out to the selected quadrant
        case (ang[15:14])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endtask

    function automatic logic [COORD_W-1:0] place(longint centre, logic [COORD_W-1:0] radius,
                                                 longint t);
        longint p;
        longint v;
        p = signed'({32'd0, radius}) * t;
        v = centre + ((p + (64'sd1 <<< 29)) >>> 30);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[COORD_W-1:0];
    endfunction

    task automatic ring_vertices(input ring_t r);
        int unsigned  n;
        int unsigned  a;
        longint       c;
        longint       s;
        vertex_pair_t vp;
        n = r.segs;
        if (n == 0)
            n = 1;
        if (n > SEG_MAX)
            n = SEG_MAX;
        for (int unsigned i = 0; i <= n; i++)
        begin
            a = r.start + (i * r.sweep) / n;
            cordic_cos_sin(a[15:0], c, s);
            vp.idx  = i[COUNT_W-1:0];
            vp.ix   = place(longint'(r.cx), r.r_in, c);
            vp.iy   = place(longint'(r.cy), r.r_in, s);
            vp.ox   = place(longint'(r.cx), r.r_out, c);
            vp.oy   = place(longint'(r.cy), r.r_out, s);
            vp.last = (i == n);
            pending_pairs.push_back(vp);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic ring_t make_ring(logic [31:0] cx, logic [31:0] cy, logic [31:0] ri,
                                        logic [31:0] ro, logic [15:0] st, logic [16:0] sw,
                                        logic [5:0] n);
        ring_t r;
        r.cx = cx;
        r.cy = cy;
        r.r_in = ri;
        r.r_out = ro;
        r.start = st;
        r.sweep = sw;
        r.segs = n;
        return r;
    endfunction

    function automatic ring_t rand_ring();
        ring_t r;
        if ($urandom_range(0, 3) == 0)
        begin
            r.cx = $urandom;
            r.cy = $urandom;
            r.r_in = $urandom;
            r.r_out = $urandom;
        end
        else
        begin
            r.cx = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            r.cy = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            r.r_in = $urandom_range(0, 32'h003F_FFFF);
            r.r_out = $urandom_range(0, 32'h00FF_FFFF);
        end
        r.start = $urandom_range(0, 65535);
        case ($urandom_range(0, 3))
            0:       r.sweep = $urandom_range(0, 131071);
            1:       r.sweep = 17'd65536;
            default: r.sweep = $urandom_range(0, 65536);
        endcase
        // keep most rings short; long ones are slow
        if ($urandom_range(0, 99) < 85)
            r.segs = $urandom_range(0, 7);
        else
            r.segs = $urandom_range(8, 63);
        return r;
    endfunction

    // Entered and left in the time step of a rising edge.
    task automatic send_ring(input ring_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.segs, r.sweep, r.start, r.r_out, r.r_in, r.cy, r.cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ring_vertices(r);
        rings_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (errors < 40)
            $display("tb_top: mismatch on %s: expected %h, got %h", what, want, got);
        errors++;
    endtask

    task automatic check_pair(input vertex_pair_t got);
        vertex_pair_t want;
        if (pending_pairs.size() == 0)
        begin
            report_mismatch("unexpected pair, index", 32'd0, 32'(got.idx));
            return;
        end
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (got.idx !== want.idx)
            report_mismatch("point_index", 32'(want.idx), 32'(got.idx));
        if (got.ix !== want.ix)
            report_mismatch($sformatf("inner_x of pair %0d", want.idx), want.ix, got.ix);
        if (got.iy !== want.iy)
            report_mismatch($sformatf("inner_y of pair %0d", want.idx), want.iy, got.iy);
        if (got.ox !== want.ox)
            report_mismatch($sformatf("outer_x of pair %0d", want.idx), want.ox, got.ox);
        if (got.oy !== want.oy)
            report_mismatch($sformatf("outer_y of pair %0d", want.idx), want.oy, got.oy);
        if (got.last !== want.last)
            report_mismatch($sformatf("tlast of pair %0d", want.idx), 32'(want.last),
                            32'(got.last));
    endtask

    // Receive side: check each transaction, then choose the next tready.
    initial
    begin
        vertex_pair_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.idx  = m_tdata[5:0];
                got.ix   = m_tdata[37:6];
                got.iy   = m_tdata[69:38];
                got.ox   = m_tdata[101:70];
                got.oy   = m_tdata[133:102];
                got.last = m_tlast;
                check_pair(got);
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("tb_top: watchdog expired, %0d pairs outstanding",
                         pending_pairs.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // full ring, unit and double radius
        send_ring(make_ring(0, 0, 32'h0001_0000, 32'h0002_0000, 0, 17'd65536, 4));
        // zero count behaves as one segment
        send_ring(make_ring(32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000, 32'h0005_0000,
                            16'd1000, 17'd20000, 0));
        send_ring(make_ring(0, 0, 32'h0001_0000, 32'h0004_0000, 0, 17'd65536, 63));
        send_ring(make_ring(32'h1234_5678, 32'h8765_4321, 32'h0000_8000, 32'h0001_8000,
                            16'd5000, 17'd0, 3));
        // sweep past one turn wraps
        send_ring(make_ring(0, 0, 32'h0010_0000, 32'h0020_0000, 16'd40000, 17'd131071, 5));
        send_ring(make_ring(0, 0, 32'h0001_0000, 32'h0002_0000, 16'd65535, 17'd65536, 2));
        // quadrant boundaries
        send_ring(make_ring(0, 0, 32'h0100_0000, 32'h0200_0000, 16'd16384, 17'd49152, 3));
        send_ring(make_ring(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'd12345, 17'd65536, 6));
        // huge radii saturate both ways
        send_ring(make_ring(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 17'd65536, 8));
        send_ring(make_ring(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                            16'd0, 17'd16384, 4));
        send_ring(make_ring(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h4000_0000,
                            16'd32768, 17'd16384, 4));
        send_ring(make_ring(32'hFFFE_0000, 32'h0002_0000, 32'h0009_0000, 32'h0001_0000,
                            16'd7000, 17'd30000, 7));
        send_ring(make_ring(0, 0, 32'h0040_0000, 32'h0080_0000, 16'd16383, 17'd1, 1));
        send_ring(make_ring(0, 0, 32'h0040_0000, 32'h0080_0000, 16'd49151, 17'd1, 63));
        send_ring(make_ring(32'hFF00_0000, 32'h00FF_0000, 32'h0002_0000, 32'h0003_0000,
                            16'd12345, 17'd65536, 63));
        send_ring(make_ring(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0003,
                            16'd65535, 17'd65535, 9));
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_ring(rand_ring());
    endtask

    // Hold the receiver off while the sender keeps offering rings.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (20)
            send_ring(rand_ring());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(0, 0, 75);
        test_random_phase(70, 0, 75);
        test_random_phase(0, 70, 75);
        test_random_phase(22, 22, 75);
        test_backpressure();
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        // let any stray pair surface
        repeat (100) @(posedge clk);
        if (pending_pairs.size() != 0)
            report_mismatch("pairs still owed", 32'd0, 32'(pending_pairs.size()));
        $display("tb_top: %0d ring requests sent, %0d vertex pairs checked", rings_sent,
                 pairs_checked);
        $display("tb_top: phases: directed corners, random with gaps and stalls, hold-off");
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
